### src/sstwm_pkg.sv
// Shared types and constants for the step-series time-weighted mean block.
`timescale 1ns / 1ps
`default_nettype none
package sstwm_pkg;

   localparam int TableDepthDefault = 256;
   localparam int DivWidth          = 64;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_LOOKUP = 2'd2,
      CMD_MEAN   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_EMPTY    = 3'd1,
      STATUS_FULL     = 3'd2,
      STATUS_ORDER    = 3'd3,
      STATUS_INTERVAL = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TAIL,
      ST_DRAIN_MUL,
      ST_DRAIN_ACC,
      ST_ROUND,
      ST_DIV_GO,
      ST_DIVIDE
   } state_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [31:0]        time_start;
      logic [31:0]        time_end;
      logic signed [31:0] sample_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic [2:0]         status;
   } rsp_type;

endpackage
`default_nettype wire

### src/sstwm_divider.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module sstwm_divider (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            go,
   input  wire logic [sstwm_pkg::DivWidth-1:0]  dividend,
   input  wire logic [31:0]                     divisor,
   output logic                                 done,
   output logic [sstwm_pkg::DivWidth-1:0]       quotient
);

   localparam int CntW = $clog2(sstwm_pkg::DivWidth + 1);

   logic [31:0]                    rem_ff, rem_in;
   logic [sstwm_pkg::DivWidth-1:0] quo_ff, quo_in;
   logic [CntW-1:0]                cnt_ff, cnt_in;
   logic                           run_ff, run_in;
   logic                           done_ff, done_in;
   logic [32:0]                    shifted;
   logic [33:0]                    diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[sstwm_pkg::DivWidth-1]};
      diff    = {1'b0, shifted} - {2'b00, divisor};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (go) begin
         rem_in = '0;
         quo_in = dividend;
         cnt_in = CntW'(sstwm_pkg::DivWidth);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (diff[33]) begin
            rem_in = shifted[31:0];
            quo_in = {quo_ff[sstwm_pkg::DivWidth-2:0], 1'b0};
         end else begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[sstwm_pkg::DivWidth-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

### src/step_series_time_weighted_mean.sv
// Top level: step-series table, lookup and time-weighted mean sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Holds up to TABLE_DEPTH time-ordered (time, value) pairs of a step function
// in a table memory with one registered read port. Clear and append finish in
// the accept cycle and the result strobes on the next cycle. A lookup walks
// the stored pairs one per cycle. A mean query walks the pairs through one
// 32x33 multiplier and accumulator, then runs one restoring divider at one
// bit per cycle. Errors strobe a result on the cycle after accept. busy is
// high while an item is at work; each result is shown for one cycle on rsp
// with rsp_strobe and cannot be held off by the receiver.
module step_series_time_weighted_mean #(
   parameter int TABLE_DEPTH = sstwm_pkg::TableDepthDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire sstwm_pkg::req_type req,
   output logic                    rsp_strobe,
   output sstwm_pkg::rsp_type      rsp
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   // table memory
   logic [31:0]        mem_time  [TABLE_DEPTH];
   logic signed [31:0] mem_value [TABLE_DEPTH];
   logic               mem_we;

   sstwm_pkg::state_type state_ff, state_in;
   sstwm_pkg::req_type   req_ff;
   sstwm_pkg::rsp_type   rsp_ff, rsp_in;
   logic                 strobe_ff, strobe_in;
   logic                 accept;

   logic [CW-1:0]        count_ff;
   logic [31:0]          last_time_ff;
   logic [31:0]          span_ff;

   logic [CW-1:0]        rd_idx_ff;
   logic                 issue;
   logic                 dv_ff;
   logic [31:0]          rd_time_ff;
   logic signed [31:0]   rd_value_ff;

   logic                 prev_vld_ff;
   logic [31:0]          prev_time_ff;
   logic signed [31:0]   prev_value_ff;
   logic signed [31:0]   lk_value_ff;

   logic                 seg_take;
   logic [31:0]          seg_hi, seg_lo_c, seg_hi_c, seg_dur;
   logic                 seg_vld_ff;
   logic [31:0]          seg_dur_ff;
   logic signed [31:0]   seg_value_ff;
   logic signed [64:0]   prod_c;
   logic                 prod_vld_ff;
   logic signed [63:0]   prod_ff;
   logic signed [63:0]   acc_ff;
   logic [63:0]          mag_ff;
   logic                 neg_ff;

   logic                 div_go;
   logic                 div_done;
   logic [sstwm_pkg::DivWidth-1:0] div_quo;
   logic [31:0]          q32;
   logic                 scan_done;
   logic                 is_mean;

   assign accept    = start && !busy;
   assign busy      = (state_ff != sstwm_pkg::ST_IDLE);
   assign is_mean   = (req_ff.cmd == sstwm_pkg::CMD_MEAN);
   assign scan_done = (rd_idx_ff == count_ff) && !dv_ff;
   assign issue     = (state_ff == sstwm_pkg::ST_SCAN) && (rd_idx_ff != count_ff);
   assign q32       = div_quo[31:0];
   assign div_go    = (state_ff == sstwm_pkg::ST_DIV_GO);

   // clipped duration of the pending segment
   always_comb begin
      seg_hi   = (state_ff == sstwm_pkg::ST_TAIL) ? req_ff.time_end : rd_time_ff;
      seg_lo_c = (prev_time_ff > req_ff.time_start) ? prev_time_ff : req_ff.time_start;
      seg_hi_c = (seg_hi < req_ff.time_end) ? seg_hi : req_ff.time_end;
      seg_dur  = (seg_hi_c > seg_lo_c) ? (seg_hi_c - seg_lo_c) : 32'd0;
      seg_take = is_mean && (((state_ff == sstwm_pkg::ST_SCAN) && dv_ff && prev_vld_ff)
                             || (state_ff == sstwm_pkg::ST_TAIL));
      prod_c   = seg_value_ff * $signed({1'b0, seg_dur_ff});
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      strobe_in = 1'b0;
      rsp_in    = '0;
      mem_we    = 1'b0;
      unique case (state_ff)
         sstwm_pkg::ST_IDLE: begin
            if (accept) begin
               strobe_in = 1'b1;
               rsp_in.status = sstwm_pkg::STATUS_OK;
               unique case (sstwm_pkg::cmd_type'(req.cmd))
                  sstwm_pkg::CMD_CLEAR: begin
                  end
                  sstwm_pkg::CMD_APPEND: begin
                     if (count_ff >= CW'(TABLE_DEPTH)) begin
                        rsp_in.status = sstwm_pkg::STATUS_FULL;
                     end else if ((count_ff != '0) && (req.time_start <= last_time_ff)) begin
                        rsp_in.status = sstwm_pkg::STATUS_ORDER;
                     end else begin
                        mem_we = 1'b1;
                     end
                  end
                  sstwm_pkg::CMD_LOOKUP: begin
                     if (count_ff == '0) begin
                        rsp_in.status = sstwm_pkg::STATUS_EMPTY;
                     end else begin
                        strobe_in = 1'b0;
                        state_in  = sstwm_pkg::ST_SCAN;
                     end
                  end
                  sstwm_pkg::CMD_MEAN: begin
                     if (count_ff == '0) begin
                        rsp_in.status = sstwm_pkg::STATUS_EMPTY;
                     end else if (req.time_end <= req.time_start) begin
                        rsp_in.status = sstwm_pkg::STATUS_INTERVAL;
                     end else begin
                        strobe_in = 1'b0;
                        state_in  = sstwm_pkg::ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         sstwm_pkg::ST_SCAN: begin
            if (scan_done) begin
               if (is_mean) begin
                  state_in = sstwm_pkg::ST_TAIL;
               end else begin
                  state_in            = sstwm_pkg::ST_IDLE;
                  strobe_in           = 1'b1;
                  rsp_in.result_value = lk_value_ff;
               end
            end
         end
         sstwm_pkg::ST_TAIL:      state_in = sstwm_pkg::ST_DRAIN_MUL;
         sstwm_pkg::ST_DRAIN_MUL: state_in = sstwm_pkg::ST_DRAIN_ACC;
         sstwm_pkg::ST_DRAIN_ACC: state_in = sstwm_pkg::ST_ROUND;
         sstwm_pkg::ST_ROUND:     state_in = sstwm_pkg::ST_DIV_GO;
         sstwm_pkg::ST_DIV_GO:    state_in = sstwm_pkg::ST_DIVIDE;
         sstwm_pkg::ST_DIVIDE: begin
            if (div_done) begin
               state_in            = sstwm_pkg::ST_IDLE;
               strobe_in           = 1'b1;
               rsp_in.result_value = neg_ff ? $signed(32'd0 - q32) : $signed(q32);
            end
         end
         default: state_in = sstwm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sstwm_pkg::ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      rsp_ff <= rsp_in;
   end

   // table memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_time[count_ff[IW-1:0]]  <= req.time_start;
         mem_value[count_ff[IW-1:0]] <= req.sample_value;
      end
      rd_time_ff  <= mem_time[rd_idx_ff[IW-1:0]];
      rd_value_ff <= mem_value[rd_idx_ff[IW-1:0]];
   end

   // pair count and last time
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept && (req.cmd == sstwm_pkg::CMD_CLEAR)) begin
         count_ff <= '0;
      end else if (mem_we) begin
         count_ff <= count_ff + 1'b1;
      end
      if (mem_we) begin
         last_time_ff <= req.time_start;
      end
   end

   // scan and accumulate datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff       <= 1'b0;
         prev_vld_ff <= 1'b0;
         seg_vld_ff  <= 1'b0;
         prod_vld_ff <= 1'b0;
         rd_idx_ff   <= '0;
      end else begin
         dv_ff       <= issue;
         seg_vld_ff  <= seg_take;
         prod_vld_ff <= seg_vld_ff;
         if (accept) begin
            rd_idx_ff   <= '0;
            prev_vld_ff <= 1'b0;
         end else begin
            if (issue) begin
               rd_idx_ff <= rd_idx_ff + 1'b1;
            end
            if ((state_ff == sstwm_pkg::ST_SCAN) && dv_ff) begin
               prev_vld_ff <= 1'b1;
            end
         end
      end
      if (accept) begin
         req_ff      <= req;
         span_ff     <= req.time_end - req.time_start;
         lk_value_ff <= '0;
         acc_ff      <= '0;
      end else begin
         if ((state_ff == sstwm_pkg::ST_SCAN) && dv_ff) begin
            prev_time_ff  <= rd_time_ff;
            prev_value_ff <= rd_value_ff;
            if (rd_time_ff <= req_ff.time_start) begin
               lk_value_ff <= rd_value_ff;
            end
         end
         if (prod_vld_ff) begin
            acc_ff <= acc_ff + prod_ff;
         end
      end
      seg_dur_ff   <= seg_dur;
      seg_value_ff <= prev_value_ff;
      prod_ff      <= prod_c[63:0];
      if (state_ff == sstwm_pkg::ST_ROUND) begin
         neg_ff <= acc_ff[63];
         mag_ff <= acc_ff[63] ? (64'd0 - acc_ff) : acc_ff;
      end
   end

   sstwm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (mag_ff + {33'd0, span_ff[31:1]}),
      .divisor  (span_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobed while busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("pair count beyond table depth");

   a_quick_cmd: assert property (@(posedge clock) disable iff (reset)
      (accept && ((req.cmd == sstwm_pkg::CMD_CLEAR) || (req.cmd == sstwm_pkg::CMD_APPEND)))
      |=> rsp_strobe)
      else $error("clear or append item gave no result");

   a_div_in_mean: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == sstwm_pkg::ST_DIVIDE))
      else $error("divider finished outside a mean query");

endmodule
`default_nettype wire

### sim/sstwm_checker.sv
// Checker: predicts step-series table results and compares them with rsp.
`timescale 1ns / 1ps
`default_nettype none
module sstwm_checker #(
   parameter int TABLE_DEPTH = 256
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire sstwm_pkg::req_type req,
   input  wire logic               rsp_strobe,
   input  wire sstwm_pkg::rsp_type rsp,
   output int                      fail_count,
   output int                      pending_count,
   output int                      result_count
);

   logic [31:0]        tbl_time [TABLE_DEPTH];
   logic signed [31:0] tbl_value [TABLE_DEPTH];
   int                 tbl_count;
   sstwm_pkg::rsp_type expected_rsp_q[$];

   function automatic logic signed [31:0] value_at(logic [31:0] t);
      int i;
      if (t < tbl_time[0]) return 0;
      i = tbl_count;
      while (i > 1 && tbl_time[i-1] > t) i--;
      return tbl_value[i-1];
   endfunction

   function automatic logic signed [31:0] weighted_mean(logic [31:0] t0, logic [31:0] t1);
      logic signed [63:0] area;
      logic [63:0]        span, mag, q;
      logic [31:0]        lo, hi, a, b;
      area = 0;
      span = {32'd0, t1} - {32'd0, t0};
      for (int i = 0; i < tbl_count; i++) begin
         lo = tbl_time[i];
         hi = (i + 1 < tbl_count) ? tbl_time[i+1] : t1;
         a = (lo > t0) ? lo : t0;
         b = (hi < t1) ? hi : t1;
         if (b > a)
            area += 64'(tbl_value[i]) * $signed({32'd0, b - a});
      end
      mag = area[63] ? 64'(-area) : 64'(area);
      q = (mag + span / 2) / span;
      return area[63] ? -q[31:0] : q[31:0];
   endfunction

   function automatic sstwm_pkg::rsp_type apply_command(sstwm_pkg::req_type r);
      sstwm_pkg::rsp_type o;
      o.result_value = 0;
      o.status = sstwm_pkg::STATUS_OK;
      case (sstwm_pkg::cmd_type'(r.cmd))
         sstwm_pkg::CMD_CLEAR: tbl_count = 0;
         sstwm_pkg::CMD_APPEND: begin
            if (tbl_count >= TABLE_DEPTH) o.status = sstwm_pkg::STATUS_FULL;
            else if (tbl_count > 0 && r.time_start <= tbl_time[tbl_count-1])
               o.status = sstwm_pkg::STATUS_ORDER;
            else begin
               tbl_time[tbl_count] = r.time_start;
               tbl_value[tbl_count] = r.sample_value;
               tbl_count++;
            end
         end
         sstwm_pkg::CMD_LOOKUP: begin
            if (tbl_count == 0) o.status = sstwm_pkg::STATUS_EMPTY;
            else o.result_value = value_at(r.time_start);
         end
         default: begin
            if (tbl_count == 0) o.status = sstwm_pkg::STATUS_EMPTY;
            else if (r.time_end <= r.time_start) o.status = sstwm_pkg::STATUS_INTERVAL;
            else o.result_value = weighted_mean(r.time_start, r.time_end);
         end
      endcase
      return o;
   endfunction

   always @(posedge clock) begin
      sstwm_pkg::rsp_type want;
      int errs;
      errs = 0;
      if (reset) begin
         tbl_count = 0;
         fail_count <= 0;
         result_count <= 0;
         pending_count <= 0;
         expected_rsp_q.delete();
      end else begin
         if (start && !busy) expected_rsp_q.push_back(apply_command(req));
         if (rsp_strobe) begin
            result_count <= result_count + 1;
            if (expected_rsp_q.size() == 0) begin
               $error("unexpected result: result_value %0d status %0d",
                      rsp.result_value, rsp.status);
               errs++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp.result_value !== want.result_value) begin
                  $error("result_value: expected %0d, got %0d",
                         want.result_value, rsp.result_value);
                  errs++;
               end
               if (rsp.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp.status);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
         pending_count <= expected_rsp_q.size();
      end
   end

endmodule
`default_nettype wire

### sim/testbench.sv
// Testbench top: drives step-series commands and reports the verdict.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

   localparam int Depth = 256;

   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   sstwm_pkg::req_type req = '0;
   logic               rsp_strobe;
   sstwm_pkg::rsp_type rsp;
   int                 fail_count, pending_count, result_count;
   int                 sender_idle_pct;
   int                 cmd_seen[4];
   logic [31:0]        next_time;

   step_series_time_weighted_mean #(.TABLE_DEPTH(Depth)) dut (
      .clock, .reset, .start, .busy, .req, .rsp_strobe, .rsp
   );

   sstwm_checker #(.TABLE_DEPTH(Depth)) check (
      .clock, .reset, .start, .busy, .req, .rsp_strobe, .rsp,
      .fail_count, .pending_count, .result_count
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   initial begin
      #20_000_000;
      $display("step_series_time_weighted_mean: mismatch");
      $finish;
   end

   // Maybe idle, then present one item and hold it until accepted.
   task automatic send_item(sstwm_pkg::cmd_type c, logic [31:0] ts, logic [31:0] te,
                            logic [31:0] v);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req <= '{cmd: c, time_start: ts, time_end: te, sample_value: v};
      @(posedge clock);
      while (busy) @(posedge clock);
      cmd_seen[c]++;
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(4))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Series run: clear, ascending appends with an occasional repeated time, then queries around them.
   task automatic send_series(int pairs, int queries);
      logic [31:0] ts, te;
      send_item(sstwm_pkg::CMD_CLEAR, $urandom, $urandom, $urandom);
      next_time = $urandom_range(1000);
      for (int i = 0; i < pairs; i++) begin
         send_item(sstwm_pkg::CMD_APPEND, next_time, $urandom, rand_word());
         if ($urandom_range(9) == 0)
            send_item(sstwm_pkg::CMD_APPEND, next_time, 0, $urandom);
         next_time += $urandom_range(($urandom_range(3) == 0) ? 32'h0100_0000 : 200, 1);
      end
      for (int i = 0; i < queries; i++) begin
         ts = ($urandom_range(7) == 0) ? rand_word() : $urandom_range(next_time + 100);
         te = ts + $urandom_range(($urandom_range(3) == 0) ? 32'h0200_0000 : 500);
         if ($urandom_range(9) == 0) te = rand_word();
         send_item(sstwm_pkg::cmd_type'($urandom_range(3, 2)), ts, te, $urandom);
      end
   endtask

   // Stop sending and wait until every predicted result has come back.
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      sender_idle_pct = 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: empty table, extremes, order errors, full table.
      send_item(sstwm_pkg::CMD_LOOKUP, 0, 0, 0);
      send_item(sstwm_pkg::CMD_MEAN, 0, 10, 0);
      send_item(sstwm_pkg::CMD_APPEND, 100, 0, 32'h7FFF_FFFF);
      send_item(sstwm_pkg::CMD_APPEND, 100, 0, 1);
      send_item(sstwm_pkg::CMD_APPEND, 50, 0, 1);
      send_item(sstwm_pkg::CMD_APPEND, 200, 0, 32'h8000_0000);
      send_item(sstwm_pkg::CMD_APPEND, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
      send_item(sstwm_pkg::CMD_LOOKUP, 99, 0, 0);
      send_item(sstwm_pkg::CMD_LOOKUP, 150, 0, 0);
      send_item(sstwm_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 0, 0);
      send_item(sstwm_pkg::CMD_MEAN, 10, 10, 0);
      send_item(sstwm_pkg::CMD_MEAN, 20, 10, 0);
      send_item(sstwm_pkg::CMD_MEAN, 0, 100, 0);
      send_item(sstwm_pkg::CMD_MEAN, 0, 150, 0);
      send_item(sstwm_pkg::CMD_MEAN, 50, 250, 0);
      send_item(sstwm_pkg::CMD_MEAN, 0, 32'hFFFF_FFFF, 0);
      send_item(sstwm_pkg::CMD_CLEAR, 0, 0, 0);
      send_item(sstwm_pkg::CMD_MEAN, 300, 301, 0);
      send_item(sstwm_pkg::CMD_APPEND, 0, 0, 32'hFFFF_0000);
      send_item(sstwm_pkg::CMD_MEAN, 300, 301, 0);
      send_item(sstwm_pkg::CMD_MEAN, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 0);
      for (int i = 1; i < Depth; i++)
         send_item(sstwm_pkg::CMD_APPEND, 32'(i), 0, $urandom);
      send_item(sstwm_pkg::CMD_APPEND, 32'hFFFF_FFFF, 0, 5);
      send_item(sstwm_pkg::CMD_MEAN, 0, 32'hFFFF_FFFF, 0);
      send_item(sstwm_pkg::CMD_LOOKUP, 128, 0, 0);
      wait_drained();

      // Random phases with different sender idling.
      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 63 : 0;
         for (int s = 0; s < 4; s++) begin
            send_series($urandom_range(12, 1), $urandom_range(8, 3));
            if (s == 1) wait_drained();
            if ($urandom_range(3) == 0)
               send_item(sstwm_pkg::cmd_type'($urandom_range(3)), rand_word(),
                         rand_word(), rand_word());
         end
      end

      wait_drained();
      repeat (2 * Depth + 200) @(posedge clock);
      $display("covered: %0d clear, %0d append, %0d lookup, %0d mean commands",
               cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3]);
      $display("results checked: %0d, table filled to depth %0d", result_count, Depth);
      if (fail_count == 0 && pending_count == 0)
         $display("step_series_time_weighted_mean: match");
      else
         $display("step_series_time_weighted_mean: mismatch");
      $finish;
   end
endmodule
`default_nettype wire
